/* design/trainer_frame_encoder_top_assert.svh */
// assertion macros for the trainer frame encoder
`ifndef TRAINER_FRAME_ENCODER_TOP_ASSERT_SVH
`define TRAINER_FRAME_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TFE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tfe assertion failed");

// next-cycle implication, checked out of reset
`define TFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tfe assertion failed");

`endif

/* design/tfe_pkg.sv */
// package for the trainer frame encoder: constants, types and payload packing
`default_nettype none

package tfe_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CHAN_W       = 12;
    localparam int PAY_BYTES    = 1 + (NUM_CHANNELS / 2) * 3;
    localparam int IN_W         = NUM_CHANNELS * CHAN_W;

    localparam logic [7:0] FRAME_TYPE = 8'h80;

    localparam logic [7:0] DELIM_RST  = 8'd126;
    localparam logic [7:0] ESC_RST    = 8'd125;
    localparam logic [7:0] MASK_RST   = 8'd32;

    // configuration register indexes
    localparam logic [1:0] CFG_DELIM  = 2'd0;
    localparam logic [1:0] CFG_ESC    = 2'd1;
    localparam logic [1:0] CFG_MASK   = 2'd2;

    // byte positions within a frame
    typedef logic [3:0] t_pos;
    localparam t_pos POS_OPEN      = 4'd0;
    localparam t_pos POS_PAY_FIRST = 4'd1;
    localparam t_pos POS_PAY_LAST  = 4'd13;
    localparam t_pos POS_CHECK     = 4'd14;
    localparam t_pos POS_CLOSE     = 4'd15;

    typedef logic [PAY_BYTES-1:0][7:0] t_payload;

    // frame type then three bytes per channel pair
    function automatic t_payload pack_payload(input logic [IN_W-1:0] chans);
        t_payload          p;
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] b;
        p[0] = FRAME_TYPE;
        for (int k = 0; k < NUM_CHANNELS / 2; k++) begin
            a = chans[(2 * k) * CHAN_W +: CHAN_W];
            b = chans[(2 * k + 1) * CHAN_W +: CHAN_W];
            p[3 * k + 1] = a[7:0];
            p[3 * k + 2] = {a[11:8], b[7:4]};
            p[3 * k + 3] = {b[3:0], b[11:8]};
        end
        return p;
    endfunction

    function automatic logic [7:0] payload_check(input t_payload p);
        logic [7:0] c;
        c = '0;
        for (int i = 0; i < PAY_BYTES; i++) begin
            c = c ^ p[i];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/trainer_frame_encoder_top.sv */
// trainer frame encoder: eight channels in, one byte-stuffed frame out byte by byte
//
// slave stream: one transaction carries eight 12-bit channels in tdata
// master stream: one byte per transaction, tlast marks the closing delimiter
// config channel: index 0 delimiter, 1 escape byte, 2 escape mask, others ignored;
//   write only while no frame is in flight
// a frame is 16 to 29 bytes: delimiter, frame type, 12 channel bytes, check, delimiter;
//   each payload byte that matches the delimiter or escape byte costs one extra byte
// the input is registered first, then the opening delimiter enters the output register
// throughput: one byte per cycle while the receiver is ready, set by the single
//   output byte register; the next frame is taken in the same cycle as the closing
//   delimiter is loaded, so frames follow back to back
// a stalled receiver holds the output register and the byte sequencer in place;
//   the input side stays ready only until a frame is loaded
// reset clears the sequencer, output valid and the config registers to their defaults
`default_nettype none

module trainer_frame_encoder_top
    import tfe_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    // slave stream
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire logic [IN_W-1:0] i_s_axis_tdata,   // chan_0 .. chan_7, 12 bits each
    // master stream
    output logic                 o_m_axis_tvalid,
    input  wire logic            i_m_axis_tready,
    output logic [7:0]           o_m_axis_tdata,   // out_byte
    output logic                 o_m_axis_tlast,   // frame_end
    // config write channel
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [7:0]      i_cfg_data
);

    // config registers
    logic [7:0] r_delim;
    logic [7:0] r_esc_byte;
    logic [7:0] r_mask;

    // frame being sent
    t_payload   r_pay;
    logic [7:0] r_chk;
    logic       r_busy;
    t_pos       r_pos;
    logic       r_esc_sent;   // escape already out for the current payload byte

    // output byte register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    t_payload   in_pay;
    logic [7:0] in_chk;
    logic       accept_in;
    logic       emit_go;
    logic [3:0] pay_idx;
    logic [7:0] pay_byte;
    logic       is_pay;
    logic       stuff;
    logic [7:0] n_out_byte;
    logic       n_out_last;
    logic       n_advance;
    logic       n_esc_sent;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim    <= DELIM_RST;
            r_esc_byte <= ESC_RST;
            r_mask     <= MASK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DELIM: r_delim    <= i_cfg_data;
                CFG_ESC:   r_esc_byte <= i_cfg_data;
                CFG_MASK:  r_mask     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // packing and check byte are done on the way into the frame register
    assign in_pay = pack_payload(i_s_axis_tdata);
    assign in_chk = payload_check(in_pay);

    // a byte moves into the output register when it is empty or being drained
    assign emit_go   = r_busy && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_busy || (emit_go && (r_pos == POS_CLOSE));
    assign accept_in = i_s_axis_tvalid && o_s_axis_tready;

    assign is_pay   = (r_pos >= POS_PAY_FIRST) && (r_pos <= POS_PAY_LAST);
    assign pay_idx  = r_pos - POS_PAY_FIRST;
    assign pay_byte = is_pay ? r_pay[pay_idx] : 8'h00;
    assign stuff    = is_pay && ((pay_byte == r_delim) || (pay_byte == r_esc_byte));

    always_comb begin
        n_out_byte = pay_byte;
        n_out_last = 1'b0;
        n_advance  = 1'b1;
        n_esc_sent = 1'b0;
        case (r_pos)
            POS_OPEN:  n_out_byte = r_delim;
            POS_CHECK: n_out_byte = r_chk;    // check byte goes out unstuffed
            POS_CLOSE: begin
                n_out_byte = r_delim;
                n_out_last = 1'b1;
            end
            default: begin
                if (stuff && !r_esc_sent) begin
                    // escape first, the masked byte follows on the next step
                    n_out_byte = r_esc_byte;
                    n_advance  = 1'b0;
                    n_esc_sent = 1'b1;
                end else if (r_esc_sent) begin
                    n_out_byte = pay_byte ^ r_mask;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pos      <= POS_OPEN;
            r_esc_sent <= 1'b0;
        end else if (accept_in) begin
            r_busy     <= 1'b1;
            r_pos      <= POS_OPEN;
            r_esc_sent <= 1'b0;
        end else if (emit_go) begin
            r_esc_sent <= n_esc_sent;
            if (n_advance) begin
                if (r_pos == POS_CLOSE) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pos <= r_pos + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_pay <= in_pay;
            r_chk <= in_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_byte <= n_out_byte;
            r_out_last <= n_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;

`include "trainer_frame_encoder_top_assert.svh"

    // a new frame only enters once the closing delimiter of the last one is going out
    `TFE_ASSERT_IMPL(a_ready_at_close, i_clk, i_rst_n,
        o_s_axis_tready, (!r_busy || (r_pos == POS_CLOSE)))
    // a pending escape only exists on a payload byte of a live frame
    `TFE_ASSERT_IMPL(a_esc_in_payload, i_clk, i_rst_n,
        r_esc_sent, (r_busy && is_pay))
    // after an escape is loaded, the next loaded byte belongs to the same position
    `TFE_ASSERT_NEXT(a_esc_holds_pos, i_clk, i_rst_n,
        (emit_go && !n_advance && !accept_in), (r_esc_sent && (r_pos == $past(r_pos))))

endmodule

`default_nettype wire
